// ----- design/rfrm_pkg.sv -----
// Shared types and constants for the receive frame rate monitor.
// No dependencies; used by rfrm_check, rfrm_ram users and the top level.

package rfrm_pkg;

   // Number of filters; the last index counts frames of every class below FILTER_COUNT.
   localparam int FILTER_COUNT = 4;
   localparam int IDX_W        = (FILTER_COUNT > 1) ? $clog2(FILTER_COUNT) : 1;
   localparam int TYPE_W       = 3;
   localparam int MASK_W       = 4;
   localparam int COUNT_W      = 32;
   localparam int TIME_W       = 48;
   localparam int DEADLINE_W   = 49;

   localparam logic [IDX_W-1:0]  ALL_IDX    = IDX_W'(FILTER_COUNT - 1);
   localparam logic [TYPE_W:0]   FILTER_NUM = (TYPE_W + 1)'(FILTER_COUNT);
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Request kinds carried in tuser bit 0
   localparam logic KIND_FRAME = 1'b0;
   localparam logic KIND_SET   = 1'b1;

   // Request beat payload, last field in the lowest bits
   typedef struct packed {
      logic [6:0]         pad;
      logic               enable;
      logic [COUNT_W-1:0] window_length;
      logic [COUNT_W-1:0] upper_limit;
      logic [COUNT_W-1:0] lower_limit;
      logic [TIME_W-1:0]  time_now;
   } req_data_type;

   typedef struct packed {
      logic [MASK_W-1:0] lack_flags;
      logic [MASK_W-1:0] over_flags;
      logic [MASK_W-1:0] lack_events;
      logic [MASK_W-1:0] over_events;
   } rsp_data_type;

   localparam int REQ_DATA_W = $bits(req_data_type);
   localparam int RSP_DATA_W = $bits(rsp_data_type);
   localparam int REQ_USER_W = 1 + TYPE_W;

   // One filter's stored state (one RAM word)
   typedef struct packed {
      logic                  enabled;
      logic [COUNT_W-1:0]    lower_bound;
      logic [COUNT_W-1:0]    upper_bound;
      logic [COUNT_W-1:0]    window_period;
      logic [COUNT_W-1:0]    window_count;
      logic [DEADLINE_W-1:0] window_deadline;
   } filter_entry_type;

   localparam int ENTRY_W = $bits(filter_entry_type);

   // Outcome of checking one filter
   typedef struct packed {
      logic over_ev;
      logic lack_ev;
      logic over_flag;
      logic lack_flag;
   } check_out_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } mon_state_type;

endpackage

// ----- design/rfrm_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.

module rfrm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/rfrm_check.sv -----
// Count and window check of one filter entry read from the state RAM.
// Depends on rfrm_pkg.

module rfrm_check (
   input  rfrm_pkg::filter_entry_type           entry_i,
   input  logic [rfrm_pkg::TIME_W-1:0]          time_now,
   input  logic                                 hit,
   input  logic                                 over_i,
   input  logic                                 lack_i,
   output rfrm_pkg::filter_entry_type           entry_o,
   output rfrm_pkg::check_out_type              chk_o
);
   import rfrm_pkg::*;

   logic [COUNT_W-1:0]    count;
   logic                  expired;
   logic [DEADLINE_W-1:0] next_deadline;

   // saturating count of this beat's frame
   always_comb begin
      count = entry_i.window_count;
      if (entry_i.enabled && hit && (count != COUNT_MAX)) begin
         count = count + COUNT_W'(1);
      end
   end

   assign expired       = {1'b0, time_now} > entry_i.window_deadline;
   assign next_deadline = {1'b0, time_now} + DEADLINE_W'(entry_i.window_period);

   // window end, then upper limit
   always_comb begin
      entry_o              = entry_i;
      entry_o.window_count = count;
      chk_o.over_ev        = 1'b0;
      chk_o.lack_ev        = 1'b0;
      chk_o.over_flag      = over_i;
      chk_o.lack_flag      = lack_i;
      if (entry_i.enabled) begin
         if (expired) begin
            chk_o.lack_ev           = count < entry_i.lower_bound;
            chk_o.lack_flag         = count < entry_i.lower_bound;
            chk_o.over_flag         = 1'b0;
            entry_o.window_count    = '0;
            entry_o.window_deadline = next_deadline;
         end else if (count > entry_i.upper_bound) begin
            chk_o.over_ev        = 1'b1;
            chk_o.over_flag      = 1'b1;
            entry_o.window_count = '0;
         end
      end
   end

endmodule

// ----- design/receive_frame_rate_monitor.sv -----
// Top level of the receive frame rate monitor (storm control filters).
// Depends on rfrm_pkg, rfrm_ram and rfrm_check.

// Filter state (enable, limits, window length, count, deadline) lives in a
// small RAM with one word per filter; over/lack flags sit in flip-flops and
// per-entry valid bits make never-loaded filters read as zero right after
// reset, so there is no clearing pass. A set beat writes its filter word (if
// its class names a filter) in the accept cycle. A frame beat walks all
// FILTER_COUNT filters through the RAM's single read port, one filter per
// cycle (read, count and check, write back). The result of either beat is
// loaded into the output register once the output slot is free, from the
// last scan step or from ST_DONE. One beat is processed at a time; a new
// beat is taken while the previous result still waits in the output register.

module receive_frame_rate_monitor (
   input  logic                               clock,
   input  logic                               reset,
   // request: tuser = {frame_type[2:0], kind} from bit 0
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [rfrm_pkg::REQ_USER_W-1:0]    req_tuser,
   // tdata: time_now[47:0], lower_limit[79:48], upper_limit[111:80],
   //        window_length[143:112], enable[144], zero pad[151:145]
   input  logic [rfrm_pkg::REQ_DATA_W-1:0]    req_tdata,
   // response tdata: over_events[3:0], lack_events[7:4],
   //                 over_flags[11:8], lack_flags[15:12]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [rfrm_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import rfrm_pkg::*;

   req_data_type          req_d;
   logic                  req_kind;
   logic [TYPE_W-1:0]     req_type;
   logic                  accept;
   logic                  type_ok;

   mon_state_type         state_ff, state_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [TYPE_W-1:0]     type_ff, type_in;
   logic [TIME_W-1:0]     now_ff, now_in;
   logic [FILTER_COUNT-1:0] over_flag_ff, over_flag_in;
   logic [FILTER_COUNT-1:0] lack_flag_ff, lack_flag_in;
   logic [FILTER_COUNT-1:0] over_ev_ff, over_ev_in;
   logic [FILTER_COUNT-1:0] lack_ev_ff, lack_ev_in;
   logic [FILTER_COUNT-1:0] valid_ff, valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_data_type          rsp_data_ff, rsp_data_in;

   logic                  slot_free;
   logic                  last;
   logic                  hit;
   logic                  load_rsp;

   logic                  ram_wr_en;
   logic [IDX_W-1:0]      ram_wr_addr;
   filter_entry_type      ram_wr_data;
   logic                  ram_rd_en;
   logic [IDX_W-1:0]      ram_rd_addr;
   logic [ENTRY_W-1:0]    ram_rd_data;

   filter_entry_type      cur_entry;
   filter_entry_type      set_entry;
   filter_entry_type      chk_entry;
   check_out_type         chk;

   // beat decode
   assign req_d     = req_tdata;
   assign req_kind  = req_tuser[0];
   assign req_type  = req_tuser[TYPE_W:1];
   assign accept    = req_tvalid && req_tready;
   assign type_ok   = {1'b0, req_type} < FILTER_NUM;
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign last      = idx_ff == ALL_IDX;

   // frame of a class below FILTER_COUNT counts into its own filter and into the all-frames filter
   assign hit = ({1'b0, type_ff} < FILTER_NUM) &&
                ((idx_ff == type_ff[IDX_W-1:0]) || last);

   // entry loaded by a set beat
   always_comb begin
      set_entry.enabled         = req_d.enable;
      set_entry.lower_bound     = req_d.lower_limit;
      set_entry.upper_bound     = req_d.upper_limit;
      set_entry.window_period   = req_d.window_length;
      set_entry.window_count    = '0;
      set_entry.window_deadline = {1'b0, req_d.time_now} +
                                  DEADLINE_W'(req_d.window_length);
   end

   // never-written entries read as the reset value
   assign cur_entry = valid_ff[idx_ff] ? filter_entry_type'(ram_rd_data) : '0;

   rfrm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (FILTER_COUNT)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   rfrm_check u_check (
      .entry_i  (cur_entry),
      .time_now (now_ff),
      .hit      (hit),
      .over_i   (over_flag_ff[idx_ff]),
      .lack_i   (lack_flag_ff[idx_ff]),
      .entry_o  (chk_entry),
      .chk_o    (chk)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_kind == KIND_SET) ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (last) begin
               state_in = slot_free ? ST_IDLE : ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // FSM outputs: handshake and RAM port control
   always_comb begin
      req_tready  = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff;
      ram_wr_data = chk_entry;
      ram_rd_en   = 1'b0;
      ram_rd_addr = '0;
      load_rsp    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            ram_rd_en   = accept && (req_kind == KIND_FRAME);
            ram_wr_en   = accept && (req_kind == KIND_SET) && type_ok;
            ram_wr_addr = req_type[IDX_W-1:0];
            ram_wr_data = set_entry;
         end
         ST_SCAN: begin
            ram_wr_en   = 1'b1;
            ram_rd_en   = !last;
            ram_rd_addr = idx_ff + IDX_W'(1);
            load_rsp    = last && slot_free;
         end
         ST_DONE: begin
            load_rsp = slot_free;
         end
         default: begin
            load_rsp = 1'b0;
         end
      endcase
   end

   // beat context, events and flags
   always_comb begin
      idx_in       = idx_ff;
      type_in      = type_ff;
      now_in       = now_ff;
      over_ev_in   = over_ev_ff;
      lack_ev_in   = lack_ev_ff;
      over_flag_in = over_flag_ff;
      lack_flag_in = lack_flag_ff;
      valid_in     = valid_ff;
      if (accept) begin
         idx_in     = '0;
         type_in    = req_type;
         now_in     = req_d.time_now;
         over_ev_in = '0;
         lack_ev_in = '0;
      end
      if (state_ff == ST_SCAN) begin
         idx_in               = idx_ff + IDX_W'(1);
         over_ev_in[idx_ff]   = chk.over_ev;
         lack_ev_in[idx_ff]   = chk.lack_ev;
         over_flag_in[idx_ff] = chk.over_flag;
         lack_flag_in[idx_ff] = chk.lack_flag;
      end
      if (ram_wr_en) begin
         valid_in[ram_wr_addr] = 1'b1;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.over_events = MASK_W'(over_ev_in);
         rsp_data_in.lack_events = MASK_W'(lack_ev_in);
         rsp_data_in.over_flags  = MASK_W'(over_flag_in);
         rsp_data_in.lack_flags  = MASK_W'(lack_flag_in);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         over_flag_ff <= '0;
         lack_flag_ff <= '0;
         over_ev_ff   <= '0;
         lack_ev_ff   <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         over_flag_ff <= over_flag_in;
         lack_flag_ff <= lack_flag_in;
         over_ev_ff   <= over_ev_in;
         lack_ev_ff   <= lack_ev_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      type_ff     <= type_in;
      now_ff      <= now_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- test/tb_top.sv -----
// Testbench for receive_frame_rate_monitor: directed filter cases,
// back-pressure and random traffic. Depends on rfrm_pkg and the
// receive_frame_rate_monitor top level; results checked by an inline predictor.
`timescale 1ns / 1ps

module tb_top;
   import rfrm_pkg::*;

   // Frame classes carried in the upper tuser bits
   localparam logic [TYPE_W-1:0] CLS_BCAST = 3'd0;
   localparam logic [TYPE_W-1:0] CLS_UCAST = 3'd1;
   localparam logic [TYPE_W-1:0] CLS_MCAST = 3'd2;
   localparam logic [TYPE_W-1:0] CLS_ALL   = 3'd3;
   localparam logic [TYPE_W-1:0] CLS_NONE  = 3'd4;

   localparam int LONG_HOLD   = 300;
   localparam int DRAIN_WAIT  = 20;
   localparam logic [TIME_W-1:0]  TIME_MAX  = '1;
   localparam logic [COUNT_W-1:0] LIMIT_MAX = '1;

   typedef struct {
      logic               kind;
      logic [TYPE_W-1:0]  frame_type;
      logic [TIME_W-1:0]  time_now;
      logic [COUNT_W-1:0] lower_limit;
      logic [COUNT_W-1:0] upper_limit;
      logic [COUNT_W-1:0] window_length;
      logic               enable;
   } monitor_req_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   receive_frame_rate_monitor uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Predicted filter state
   logic                  flt_enabled  [FILTER_COUNT];
   logic [COUNT_W-1:0]    flt_lower    [FILTER_COUNT];
   logic [COUNT_W-1:0]    flt_upper    [FILTER_COUNT];
   logic [COUNT_W-1:0]    flt_period   [FILTER_COUNT];
   logic [COUNT_W-1:0]    flt_count    [FILTER_COUNT];
   logic [DEADLINE_W-1:0] flt_deadline [FILTER_COUNT];
   logic                  flt_over     [FILTER_COUNT];
   logic                  flt_lack     [FILTER_COUNT];

   rsp_data_type expected_events_q[$];
   int           error_count = 0;
   logic         gaps_on     = 1'b1;
   int           sink_wait   = 0;
   logic         sink_hold   = 1'b0;
   logic [TIME_W-1:0] now_us = '0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb_top: errors");
      $finish;
   end

   // Frame counter bump, saturating, only into enabled filters
   function automatic void bump_count(int idx);
      if (flt_enabled[idx] && flt_count[idx] != LIMIT_MAX)
         flt_count[idx] = flt_count[idx] + COUNT_W'(1);
   endfunction

   // Events and flags caused by one request beat
   function automatic rsp_data_type predict_rate_events(monitor_req_type r);
      rsp_data_type res;
      int           idx;
      res = '0;
      idx = int'(r.frame_type);
      if (r.kind == KIND_SET) begin
         if (idx < FILTER_COUNT) begin
            flt_lower[idx]    = r.lower_limit;
            flt_upper[idx]    = r.upper_limit;
            flt_period[idx]   = r.window_length;
            flt_count[idx]    = '0;
            flt_deadline[idx] = {1'b0, r.time_now} + DEADLINE_W'(r.window_length);
            flt_enabled[idx]  = r.enable;
         end
      end else begin
         if (idx < FILTER_COUNT) begin
            bump_count(idx);
            if (idx != FILTER_COUNT - 1)
               bump_count(FILTER_COUNT - 1);
         end
         for (int i = 0; i < FILTER_COUNT; i++) begin
            if (!flt_enabled[i])
               continue;
            if ({1'b0, r.time_now} > flt_deadline[i]) begin
               // window closed: judge the lower limit and restart
               flt_lack[i] = (flt_lower[i] > flt_count[i]);
               if (flt_lack[i] && i < MASK_W)
                  res.lack_events[i] = 1'b1;
               flt_over[i]     = 1'b0;
               flt_count[i]    = '0;
               flt_deadline[i] = {1'b0, r.time_now} + DEADLINE_W'(flt_period[i]);
            end else if (flt_count[i] > flt_upper[i]) begin
               flt_over[i]  = 1'b1;
               flt_count[i] = '0;
               if (i < MASK_W)
                  res.over_events[i] = 1'b1;
            end
         end
      end
      for (int i = 0; i < FILTER_COUNT && i < MASK_W; i++) begin
         res.over_flags[i] = flt_over[i];
         res.lack_flags[i] = flt_lack[i];
      end
      return res;
   endfunction

   // Drive one request beat and wait until it is taken
   task automatic send_beat(monitor_req_type r);
      req_data_type payload;
      int           gap;
      payload = '0;
      payload.time_now      = r.time_now;
      payload.lower_limit   = r.lower_limit;
      payload.upper_limit   = r.upper_limit;
      payload.window_length = r.window_length;
      payload.enable        = r.enable;
      gap = gaps_on ? $urandom_range(0, 19) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= {r.frame_type, r.kind};
      req_tdata  <= payload;
      forever begin
         @(posedge clock);
         if (req_tready)
            break;
      end
      expected_events_q.push_back(predict_rate_events(r));
   endtask

   task automatic send_set(logic [TYPE_W-1:0] ftype, logic [COUNT_W-1:0] lower,
                           logic [COUNT_W-1:0] upper, logic [COUNT_W-1:0] window,
                           logic en, logic [TIME_W-1:0] t);
      monitor_req_type r;
      r.kind = KIND_SET;  r.frame_type = ftype;  r.time_now = t;
      r.lower_limit = lower;  r.upper_limit = upper;  r.window_length = window;
      r.enable = en;
      send_beat(r);
   endtask

   task automatic send_frame(logic [TYPE_W-1:0] ftype, logic [TIME_W-1:0] t);
      monitor_req_type r;
      r.kind = KIND_FRAME;  r.frame_type = ftype;  r.time_now = t;
      // unused fields still carry random bits
      r.lower_limit = $urandom;  r.upper_limit = $urandom;  r.window_length = $urandom;
      r.enable = 1'($urandom);
      send_beat(r);
   endtask

   // Fully random beat: any kind, class and time
   task automatic send_noise();
      monitor_req_type r;
      r.kind       = 1'($urandom);
      r.frame_type = TYPE_W'($urandom_range(0, 7));
      if ($urandom_range(0, 1))
         r.time_now = {16'($urandom), $urandom};
      else
         r.time_now = now_us - TIME_W'($urandom_range(0, 50));
      r.lower_limit   = $urandom;
      r.upper_limit   = $urandom;
      r.window_length = $urandom;
      r.enable        = 1'($urandom);
      send_beat(r);
   endtask

   // Stop offering beats, then wait for every pending result
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_events_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic compare_mask(string field, logic [MASK_W-1:0] want, logic [MASK_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", field, want, got);
         error_count++;
      end
   endtask

   // Result checker: compare each response beat with the oldest prediction
   always @(posedge clock) begin : rsp_check
      rsp_data_type got;
      rsp_data_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         got = rsp_tdata;
         sink_wait = gaps_on ? $urandom_range(0, 19) : 0;
         if (expected_events_q.size() == 0) begin
            $error("response beat %h with nothing pending", got);
            error_count++;
         end else begin
            want = expected_events_q.pop_front();
            compare_mask("over_events", want.over_events, got.over_events);
            compare_mask("lack_events", want.lack_events, got.lack_events);
            compare_mask("over_flags",  want.over_flags,  got.over_flags);
            compare_mask("lack_flags",  want.lack_flags,  got.lack_flags);
         end
      end
   end

   // Response sink: random stalls plus a long hold on request
   initial begin : rsp_sink
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (sink_hold) begin
            hold_left = LONG_HOLD;
            sink_hold = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (sink_wait > 0) begin
            sink_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Limits, classes, window end, disable and wide deadlines
   task automatic test_directed_cases();
      send_frame(CLS_BCAST, '0);
      send_frame(CLS_NONE, 48'd5);
      send_set(CLS_BCAST, 32'd2, 32'd1, 32'd100, 1'b1, '0);
      send_set(CLS_ALL, '0, LIMIT_MAX, 32'd50, 1'b1, '0);
      send_frame(CLS_BCAST, 48'd10);
      send_frame(CLS_BCAST, 48'd20);
      send_frame(CLS_ALL, 48'd30);
      send_frame(CLS_NONE, 48'd40);
      send_frame(CLS_UCAST, 48'd60);
      send_frame(CLS_NONE, 48'd200);
      send_set(CLS_UCAST, LIMIT_MAX, '0, '0, 1'b1, 48'd200);
      send_frame(CLS_UCAST, 48'd200);
      send_frame(CLS_UCAST, 48'd201);
      send_set(CLS_MCAST, '0, '0, LIMIT_MAX, 1'b1, TIME_MAX);
      send_frame(CLS_MCAST, TIME_MAX);
      send_frame(CLS_MCAST, TIME_MAX);
      send_set(3'd7, $urandom, $urandom, $urandom, 1'b1, '0);
      send_set(CLS_NONE, $urandom, $urandom, $urandom, 1'b1, TIME_MAX);
      send_set(CLS_BCAST, 32'd3, 32'd3, 32'd10, 1'b0, '0);
      send_frame(CLS_BCAST, TIME_MAX);
      send_frame(3'd5, '0);
      send_set(CLS_ALL, '0, '0, '0, 1'b0, '0);
      send_frame(3'd6, 48'd1);
   endtask

   // Long response hold while requests keep coming, then a full drain
   task automatic test_back_pressure();
      gaps_on = 1'b0;
      now_us  = 48'd1000;
      send_set(CLS_BCAST, 32'd1, 32'd2, 32'd40, 1'b1, now_us);
      send_set(CLS_ALL, 32'd4, 32'd6, 32'd60, 1'b1, now_us);
      sink_hold = 1'b1;
      for (int n = 0; n < 40; n++) begin
         now_us = now_us + TIME_W'($urandom_range(0, 12));
         send_frame(TYPE_W'($urandom_range(0, 4)), now_us);
      end
      wait_drained();
   endtask

   // Well-formed windows of traffic with random content and some noise
   task automatic test_windowed_traffic();
      int pick;
      for (int phase = 0; phase < 8; phase++) begin
         gaps_on = (phase % 3 != 1);
         now_us  = {8'($urandom_range(0, 254)), 8'($urandom), $urandom};
         for (int f = 0; f < FILTER_COUNT; f++) begin
            if (phase == 5)
               send_set(TYPE_W'(f), $urandom, $urandom, $urandom, 1'($urandom), now_us);
            else if (phase == 6)
               send_set(TYPE_W'(f), $urandom_range(0, 3), '0, '0, 1'b1, now_us);
            else
               send_set(TYPE_W'(f), $urandom_range(0, 6), $urandom_range(0, 8),
                        $urandom_range(10, 300), $urandom_range(0, 4) != 0, now_us);
         end
         for (int n = 0; n < 100; n++) begin
            if ($urandom_range(0, 9) == 0)
               now_us = now_us + TIME_W'($urandom_range(100, 600));
            else
               now_us = now_us + TIME_W'($urandom_range(0, 30));
            pick = $urandom_range(0, 99);
            if (pick < 10)
               send_noise();
            else if (pick < 35)
               send_frame(CLS_BCAST, now_us);
            else if (pick < 57)
               send_frame(CLS_UCAST, now_us);
            else if (pick < 77)
               send_frame(CLS_MCAST, now_us);
            else if (pick < 92)
               send_frame(CLS_ALL, now_us);
            else
               send_frame(TYPE_W'($urandom_range(CLS_NONE, 7)), now_us);
         end
      end
   endtask

   initial begin
      for (int i = 0; i < FILTER_COUNT; i++) begin
         flt_enabled[i] = 1'b0;  flt_lower[i] = '0;  flt_upper[i] = '0;
         flt_period[i]  = '0;    flt_count[i] = '0;  flt_deadline[i] = '0;
         flt_over[i]    = 1'b0;  flt_lack[i]  = 1'b0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_back_pressure();
      test_windowed_traffic();

      @(negedge clock);
      req_tvalid <= 1'b0;
      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule

// ----- filelist.f -----
design/rfrm_pkg.sv
design/rfrm_ram.sv
design/rfrm_check.sv
design/receive_frame_rate_monitor.sv
test/tb_top.sv
